// File: rtl/core/tsd_pkg.sv
package tsd_pkg;

   // Telnet protocol bytes
   localparam logic [7:0] TN_IAC  = 8'd255;
   localparam logic [7:0] TN_SE   = 8'd240;
   localparam logic [7:0] TN_SB   = 8'd250;
   localparam logic [7:0] TN_WILL = 8'd251;
   localparam logic [7:0] TN_WONT = 8'd252;
   localparam logic [7:0] TN_DO   = 8'd253;
   localparam logic [7:0] TN_DONT = 8'd254;

   // Parser phase
   typedef enum logic [2:0] {
      PH_DATA   = 3'd0,
      PH_IAC    = 3'd1,
      PH_VERB   = 3'd2,
      PH_SBOPT  = 3'd3,
      PH_SUB    = 3'd4,
      PH_SUBIAC = 3'd5
   } phase_type;

   // Event kinds reported on the result channel
   typedef enum logic [2:0] {
      EV_APP_DATA  = 3'd0,
      EV_COMMAND   = 3'd1,
      EV_NEGOTIATE = 3'd2,
      EV_SUB_START = 3'd3,
      EV_SUB_DATA  = 3'd4,
      EV_SUB_END   = 3'd5
   } kind_type;

   // One result transaction
   typedef struct packed {
      logic [7:0] data_byte;
      logic [7:0] option_byte;
      logic [7:0] code_byte;
      kind_type   event_kind;
      logic       last;
   } event_type;

   // Decode of one byte: how many events and what they are
   typedef struct packed {
      logic [1:0] nres;
      event_type  ev0;
      event_type  ev1;
   } decode_type;

endpackage

// File: rtl/core/tsd_parser.sv
module tsd_parser
   import tsd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] rx_byte,
   output decode_type dec
);

   phase_type  phase_ff, phase_in;
   logic [7:0] verb_ff, verb_in;
   logic [7:0] sub_opt_ff, sub_opt_in;

   // State registers, advanced only when a byte is consumed
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_DATA;
         verb_ff    <= '0;
         sub_opt_ff <= '0;
      end else if (step) begin
         phase_ff   <= phase_in;
         verb_ff    <= verb_in;
         sub_opt_ff <= sub_opt_in;
      end
   end

   // Next phase and the events caused by this byte
   always_comb begin
      phase_in   = PH_DATA;
      verb_in    = verb_ff;
      sub_opt_in = sub_opt_ff;
      dec        = '0;
      dec.ev0.last = 1'b1;
      dec.ev1.last = 1'b1;
      case (phase_ff)
         PH_IAC: begin
            if (rx_byte inside {[TN_WILL:TN_DONT]}) begin
               verb_in  = rx_byte;
               phase_in = PH_VERB;
            end else if (rx_byte == TN_SB) begin
               phase_in = PH_SBOPT;
            end else begin
               dec.nres          = 2'd1;
               dec.ev0.event_kind = EV_COMMAND;
               dec.ev0.code_byte  = rx_byte;
            end
         end
         PH_VERB: begin
            dec.nres            = 2'd1;
            dec.ev0.event_kind  = EV_NEGOTIATE;
            dec.ev0.code_byte   = verb_ff;
            dec.ev0.option_byte = rx_byte;
         end
         PH_SBOPT: begin
            sub_opt_in          = rx_byte;
            phase_in            = PH_SUB;
            dec.nres            = 2'd1;
            dec.ev0.event_kind  = EV_SUB_START;
            dec.ev0.option_byte = rx_byte;
         end
         PH_SUB: begin
            if (rx_byte == TN_IAC) begin
               phase_in = PH_SUBIAC;
            end else begin
               phase_in            = PH_SUB;
               dec.nres            = 2'd1;
               dec.ev0.event_kind  = EV_SUB_DATA;
               dec.ev0.option_byte = sub_opt_ff;
               dec.ev0.data_byte   = rx_byte;
            end
         end
         PH_SUBIAC: begin
            if (rx_byte == TN_SE) begin
               dec.nres            = 2'd1;
               dec.ev0.event_kind  = EV_SUB_END;
               dec.ev0.option_byte = sub_opt_ff;
            end else begin
               // raw pass-through of the escape and the byte after it
               phase_in            = PH_SUB;
               dec.nres            = 2'd2;
               dec.ev0.event_kind  = EV_SUB_DATA;
               dec.ev0.option_byte = sub_opt_ff;
               dec.ev0.data_byte   = TN_IAC;
               dec.ev0.last        = 1'b0;
               dec.ev1.event_kind  = EV_SUB_DATA;
               dec.ev1.option_byte = sub_opt_ff;
               dec.ev1.data_byte   = rx_byte;
            end
         end
         default: begin
            if (rx_byte == TN_IAC) begin
               phase_in = PH_IAC;
            end else begin
               dec.nres          = 2'd1;
               dec.ev0.event_kind = EV_APP_DATA;
               dec.ev0.data_byte  = rx_byte;
            end
         end
      endcase
   end

endmodule

// File: rtl/core/telnet_stream_deframer.sv
// Channel   Dir  Transaction
// req_*     in   one received telnet byte (tdata[7:0])
// rsp_*     out  one event; tuser gives its kind, tlast marks the final event of its byte
//
// A byte sits in the input register, is decoded combinationally and its first
// event lands in the output register; one byte per clock is sustained unless stalled.
// A byte inside a subnegotiation that releases a held IAC gives two events:
// the second waits in a pending register and the input stalls until it moves to the output.
// Reset is synchronous and returns the parser to the plain data phase.
// Backpressure on rsp_tready holds the output register and then the input.
module telnet_stream_deframer
   import tsd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] code_byte, [15:8] option_byte,
                                    // [23:16] data_byte
   output logic [2:0]  rsp_tuser,   // [2:0] event_kind
   output logic        rsp_tlast
);

   logic       in_vld_ff;
   logic [7:0] in_byte_ff;
   logic       out_vld_ff;
   event_type  out_ev_ff;
   logic       pend_vld_ff;
   event_type  pend_ev_ff;

   decode_type dec;
   logic       out_free;
   logic       consume;

   tsd_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .step    (consume),
      .rx_byte (in_byte_ff),
      .dec     (dec)
   );

   // Handshake control
   assign out_free   = !out_vld_ff || rsp_tready;
   assign consume    = in_vld_ff && !pend_vld_ff && ((dec.nres == 2'd0) || out_free);
   assign req_tready = !in_vld_ff || consume;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_tready) begin
         in_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
      end
   end

   // Output and pending registers
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         pend_vld_ff <= 1'b0;
      end else if (pend_vld_ff && out_free) begin
         out_vld_ff  <= 1'b1;
         pend_vld_ff <= 1'b0;
      end else if (consume && (dec.nres != 2'd0)) begin
         out_vld_ff  <= 1'b1;
         pend_vld_ff <= (dec.nres == 2'd2);
      end else if (rsp_tready) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pend_vld_ff && out_free) begin
         out_ev_ff <= pend_ev_ff;
      end else if (consume && (dec.nres != 2'd0)) begin
         out_ev_ff  <= dec.ev0;
         pend_ev_ff <= dec.ev1;
      end
   end

   // Result channel
   assign rsp_tvalid = out_vld_ff;
   assign rsp_tlast  = out_ev_ff.last;
   assign rsp_tuser  = out_ev_ff.event_kind;
   assign rsp_tdata  = {out_ev_ff.data_byte, out_ev_ff.option_byte, out_ev_ff.code_byte};

`ifndef SYNTHESIS
   // a pending second event always sits behind a shown first one
   a_pend_behind_out: assert property (@(posedge clock) disable iff (reset)
      pend_vld_ff |-> out_vld_ff)
      else $error("pending event without an output event");

   // a non-final event is always followed by its pending partner
   a_first_has_second: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && !out_ev_ff.last) |-> pend_vld_ff)
      else $error("non-final event without a following event");

   // no byte is decoded while a second event is still pending
   a_no_consume_pending: assert property (@(posedge clock) disable iff (reset)
      pend_vld_ff |-> !consume)
      else $error("byte consumed while an event is pending");
`endif

endmodule
